// File: design/look_at_view_matrix_top_macros.svh
// Assertion shorthands used by the look-at view matrix top design file.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LAVM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LAVM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lavm_pkg.sv
package lavm_pkg;

    // Width of every coordinate and matrix entry.
    localparam int COORD_WIDTH   = 32;
    localparam int DEF_FRAC_BITS = 16;

    // Row number of the constant bottom row of the matrix.
    localparam logic [1:0] LAST_ROW = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] eye_x;
        logic signed [COORD_WIDTH-1:0] eye_y;
        logic signed [COORD_WIDTH-1:0] eye_z;
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
        logic signed [COORD_WIDTH-1:0] target_z;
        logic signed [COORD_WIDTH-1:0] up_x;
        logic signed [COORD_WIDTH-1:0] up_y;
        logic signed [COORD_WIDTH-1:0] up_z;
    } t_in_req;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] col0;
        logic signed [COORD_WIDTH-1:0] col1;
        logic signed [COORD_WIDTH-1:0] col2;
        logic signed [COORD_WIDTH-1:0] col3;
        logic [1:0]                    row_index;
        logic                          last_row;
        logic                          degenerate;
    } t_out_req;

endpackage

// File: design/lavm_norm.sv
module lavm_norm import lavm_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH:0]   i_vec [3],
    output logic                          o_valid,
    output logic signed [FRAC_BITS+1:0]   o_vec [3],
    output logic                          o_ok
);

    localparam int W   = COORD_WIDTH;
    localparam int MW  = W + 1;          // magnitude of a difference
    localparam int SW  = 2 * MW;         // sum of three squares
    localparam int RB  = W + 1;          // bits of the integer square root
    localparam int RMW = RB + 3;         // root remainder
    localparam int DRW = RB + 1;         // divider partial remainder
    localparam int QB  = FRAC_BITS + 1;  // quotient bits, at most one integer bit
    localparam int NS  = 3 + RB + QB + 1;

    logic [NS-1:0] r_v;

    logic [MW-1:0] r_mag_a [3];
    logic          r_neg_a [3];
    logic [SW-1:0] r_sq    [3];
    logic [MW-1:0] r_mag_b [3];
    logic          r_neg_b [3];
    logic [SW-1:0] r_sum;
    logic [MW-1:0] r_mag_c [3];
    logic          r_neg_c [3];

    logic [SW-1:0]  r_rad  [RB];
    logic [RMW-1:0] r_rem  [RB];
    logic [RB-1:0]  r_root [RB];
    logic [MW-1:0]  r_sm   [RB][3];
    logic           r_sn   [RB][3];

    logic [RB-1:0]  r_len [QB];
    logic [DRW-1:0] r_dr  [QB][3];
    logic [QB-1:0]  r_q   [QB][3];
    logic           r_dn  [QB][3];

    logic signed [FRAC_BITS+1:0] r_out [3];
    logic                        r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // Magnitudes, squares and their sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag_a[i] <= i_vec[i][W] ? MW'(-i_vec[i]) : MW'(i_vec[i]);
                r_neg_a[i] <= i_vec[i][W];
                r_sq[i]    <= r_mag_a[i] * r_mag_a[i];
                r_mag_b[i] <= r_mag_a[i];
                r_neg_b[i] <= r_neg_a[i];
                r_mag_c[i] <= r_mag_b[i];
                r_neg_c[i] <= r_neg_b[i];
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic [SW-1:0]  s_rad;
        logic [RMW-1:0] s_rem;
        logic [RB-1:0]  s_root;
        logic [MW-1:0]  s_mag [3];
        logic           s_neg [3];
        logic [RMW-1:0] w_sh;
        logic [RMW-1:0] w_tr;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign s_rad  = r_sum;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_mag  = r_mag_c;
            assign s_neg  = r_neg_c;
        end else begin : g_next
            assign s_rad  = r_rad[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_mag  = r_sm[k-1];
            assign s_neg  = r_sn[k-1];
        end

        assign w_sh = {s_rem[RMW-3:0], s_rad[SW-1 -: 2]};
        assign w_tr = {1'b0, s_root, 2'b01};
        assign w_ge = (w_sh >= w_tr);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= s_rad << 2;
                r_rem[k]  <= w_ge ? (w_sh - w_tr) : w_sh;
                r_root[k] <= {s_root[RB-2:0], w_ge};
                r_sm[k]   <= s_mag;
                r_sn[k]   <= s_neg;
            end
        end
    end

    // Restoring division of each magnitude by the length, one quotient bit per stage.
    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [RB-1:0]  s_len;
        logic [DRW-1:0] s_r [3];
        logic [QB-1:0]  s_q [3];
        logic           s_neg [3];
        logic           w_ge [3];

        if (j == 0) begin : g_first
            assign s_len = r_root[RB-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign s_r[i] = DRW'(r_sm[RB-1][i]);
                assign s_q[i] = '0;
            end
            assign s_neg = r_sn[RB-1];
        end else begin : g_next
            assign s_len = r_len[j-1];
            assign s_r   = r_dr[j-1];
            assign s_q   = r_q[j-1];
            assign s_neg = r_dn[j-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_ge[i] = (s_r[i] >= DRW'(s_len));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[j] <= s_len;
                r_dn[j]  <= s_neg;
                for (int i = 0; i < 3; i++) begin
                    r_dr[j][i] <= (w_ge[i] ? (s_r[i] - DRW'(s_len)) : s_r[i]) << 1;
                    r_q[j][i]  <= {s_q[i][QB-2:0], w_ge[i]};
                end
            end
        end
    end

    // Sign back on; a zero length gives the zero vector.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok <= (r_len[QB-1] != '0);
            for (int i = 0; i < 3; i++) begin
                if (r_len[QB-1] == '0) begin
                    r_out[i] <= '0;
                end else if (r_dn[QB-1][i]) begin
                    r_out[i] <= -$signed({1'b0, r_q[QB-1][i]});
                end else begin
                    r_out[i] <= $signed({1'b0, r_q[QB-1][i]});
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_vec   = r_out;
    assign o_ok    = r_ok;

endmodule

// File: design/look_at_view_matrix_top.sv
// Row 0 of a request comes out once the request has passed the input register, the normalizers
// and the product stages; rows 1 to 3 follow on the next cycles when the sink is ready.
// Flow: four rows per request; the output row register, emitting one row per cycle while the
// sink is ready, limits the request rate; the stages behind it take one per cycle unless stalled.
// Reset: i_rst_n is synchronous, active low, and clears every valid bit and the row counter.
`include "look_at_view_matrix_top_macros.svh"

module look_at_view_matrix_top import lavm_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    // Widths of the internal values. Normalized components stay within plus or minus one,
    // the left vector within two and the true up vector within four, so the rotation part
    // of every row fits in RW bits. Dot products with the eye grow by a few bits over W.
    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int NW  = F + 2;
    localparam int NL  = W + F + 6;
    localparam int RW  = F + 4;
    localparam int P1W = 2 * F + 2;
    localparam int P3W = 2 * F + 4;
    localparam int P5W = RW - 1 + W;
    localparam int SXW = RW + W + 3;

    // Operand pairs of a cross product: out[i] = a[CA[2i]]*b[CB[2i]] - a[CA[2i+1]]*b[CB[2i+1]].
    localparam int CA [6] = '{1, 2, 2, 0, 0, 1};
    localparam int CB [6] = '{2, 1, 0, 2, 1, 0};

    localparam logic signed [SXW-1:0] SAT_HI = (SXW'(1) <<< (W - 1)) - SXW'(1);
    localparam logic signed [SXW-1:0] SAT_LO = -SAT_HI - SXW'(1);
    localparam logic signed [SXW-1:0] ONE_X  = SXW'(1) <<< F;

    function automatic logic signed [W-1:0] sat_w(input logic signed [SXW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // The whole pipeline advances together. It only stops when its last stage holds a
    // request that the output row register cannot take yet, so bubbles are squeezed out
    // and a stall neither drops nor repeats anything.
    logic w_en;
    logic w_hold_free;

    // Stage 0: input register, target minus eye formed exactly.
    logic signed [W-1:0] w_eye [3];
    logic signed [W-1:0] w_tgt [3];
    logic signed [W-1:0] w_upi [3];
    logic                r_s0_v;
    logic signed [W:0]   r_d0  [3];
    logic signed [W:0]   r_up0 [3];
    logic signed [W-1:0] r_e0  [3];

    // The eye rides alongside the normalizers.
    logic signed [W-1:0] r_ed [NL][3];

    logic                w_f_v;
    logic                w_u_v;
    logic                w_f_ok;
    logic                w_u_ok;
    logic signed [NW-1:0] w_f [3];
    logic signed [NW-1:0] w_u [3];

    // Stage 1: products of forward and normalized up.
    logic [NW-2:0]        w_fm [3];
    logic [NW-2:0]        w_um [3];
    logic                 r_v1;
    logic [P1W-1:0]       r_p1 [6];
    logic                 r_n1 [6];
    logic signed [NW-1:0] r_f1 [3];
    logic signed [W-1:0]  r_e1 [3];
    logic                 r_deg1;

    // Stage 2: left vector.
    logic [F+1:0]         w_s2m [6];
    logic signed [RW-1:0] w_s2t [6];
    logic signed [RW-1:0] w_l   [3];
    logic                 r_v2;
    logic signed [RW-1:0] r_l2 [3];
    logic signed [NW-1:0] r_f2 [3];
    logic signed [W-1:0]  r_e2 [3];
    logic                 r_deg2;

    // Stage 3: products of left and forward.
    logic [RW-2:0]        w_lm  [3];
    logic [NW-2:0]        w_f2m [3];
    logic                 r_v3;
    logic [P3W-1:0]       r_p3 [6];
    logic                 r_n3 [6];
    logic signed [RW-1:0] r_l3 [3];
    logic signed [NW-1:0] r_f3 [3];
    logic signed [W-1:0]  r_e3 [3];
    logic                 r_deg3;

    // Stage 4: true up vector.
    logic [P3W-F-1:0]      w_s4m [6];
    logic signed [RW:0]    w_s4t [6];
    logic signed [RW:0]    w_t   [3];
    logic                  r_v4;
    logic signed [RW-1:0]  r_t4 [3];
    logic signed [RW-1:0]  r_l4 [3];
    logic signed [NW-1:0]  r_f4 [3];
    logic signed [W-1:0]   r_e4 [3];
    logic                  r_deg4;

    // Stage 5: the three rotation rows and their products with the eye.
    logic signed [RW-1:0] w_row [3][3];
    logic [RW-2:0]        w_rm  [3][3];
    logic [W-1:0]         w_em  [3];
    logic                 r_v5;
    logic signed [RW-1:0] r_row5 [3][3];
    logic [P5W-1:0]       r_p5   [3][3];
    logic                 r_n5   [3][3];
    logic                 r_deg5;

    // Output row register: the finished matrix, handed out one row per cycle while the sink is ready.
    logic [P5W-F-1:0]      w_hsh [3][3];
    logic signed [SXW-1:0] w_ht  [3][3];
    logic signed [SXW-1:0] w_dot [3];
    logic                  r_hv;
    logic [1:0]            r_row;
    logic signed [W-1:0]   r_hold [3][4];
    logic                  r_hdeg;

    assign w_hold_free = !r_hv || (i_out_ready && (r_row == LAST_ROW));
    assign w_en        = !r_v5 || w_hold_free;
    assign o_in_ready  = w_en;

    assign w_eye[0] = i_in_req.eye_x;
    assign w_eye[1] = i_in_req.eye_y;
    assign w_eye[2] = i_in_req.eye_z;
    assign w_tgt[0] = i_in_req.target_x;
    assign w_tgt[1] = i_in_req.target_y;
    assign w_tgt[2] = i_in_req.target_z;
    assign w_upi[0] = i_in_req.up_x;
    assign w_upi[1] = i_in_req.up_y;
    assign w_upi[2] = i_in_req.up_z;

    // Valid bits travel with the data; the row counter steps on each row taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_hv   <= 1'b0;
            r_row  <= '0;
        end else begin
            if (w_en) begin
                r_s0_v <= i_in_valid;
                r_v1   <= w_f_v;
                r_v2   <= r_v1;
                r_v3   <= r_v2;
                r_v4   <= r_v3;
                r_v5   <= r_v4;
            end
            if (w_hold_free) begin
                r_hv <= r_v5;
            end
            if (o_out_valid && i_out_ready) begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d0[i]  <= {w_tgt[i][W-1], w_tgt[i]} - {w_eye[i][W-1], w_eye[i]};
                r_up0[i] <= {w_upi[i][W-1], w_upi[i]};
                r_e0[i]  <= w_eye[i];
            end
            r_ed[0] <= r_e0;
            for (int k = 1; k < NL; k++) begin
                r_ed[k] <= r_ed[k-1];
            end
        end
    end

    // Forward and up are normalized side by side in two identical pipelines.
    lavm_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_v),
        .i_vec   (r_d0),
        .o_valid (w_f_v),
        .o_vec   (w_f),
        .o_ok    (w_f_ok)
    );

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_v),
        .i_vec   (r_up0),
        .o_valid (w_u_v),
        .o_vec   (w_u),
        .o_ok    (w_u_ok)
    );

    // Products are taken on magnitudes, so the shift by F truncates toward zero.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fm[i] = (NW-1)'((w_f[i] < 0) ? -w_f[i] : w_f[i]);
            w_um[i] = (NW-1)'((w_u[i] < 0) ? -w_u[i] : w_u[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                r_p1[j] <= w_fm[CA[j]] * w_um[CB[j]];
                r_n1[j] <= (w_f[CA[j]] < 0) != (w_u[CB[j]] < 0);
            end
            r_f1   <= w_f;
            r_e1   <= r_ed[NL-1];
            r_deg1 <= !w_f_ok || !w_u_ok;
        end
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            w_s2m[j] = (F+2)'(r_p1[j] >> F);
            w_s2t[j] = r_n1[j] ? -RW'($signed({1'b0, w_s2m[j]}))
                               : RW'($signed({1'b0, w_s2m[j]}));
        end
        for (int i = 0; i < 3; i++) begin
            w_l[i] = w_s2t[2*i] - w_s2t[2*i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l2   <= w_l;
            r_f2   <= r_f1;
            r_e2   <= r_e1;
            r_deg2 <= r_deg1 || ((w_l[0] == '0) && (w_l[1] == '0) && (w_l[2] == '0));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lm[i]  = (RW-1)'((r_l2[i] < 0) ? -r_l2[i] : r_l2[i]);
            w_f2m[i] = (NW-1)'((r_f2[i] < 0) ? -r_f2[i] : r_f2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                r_p3[j] <= w_lm[CA[j]] * w_f2m[CB[j]];
                r_n3[j] <= (r_l2[CA[j]] < 0) != (r_f2[CB[j]] < 0);
            end
            r_l3   <= r_l2;
            r_f3   <= r_f2;
            r_e3   <= r_e2;
            r_deg3 <= r_deg2;
        end
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            w_s4m[j] = (P3W-F)'(r_p3[j] >> F);
            w_s4t[j] = r_n3[j] ? -(RW+1)'($signed({1'b0, w_s4m[j]}))
                               : (RW+1)'($signed({1'b0, w_s4m[j]}));
        end
        for (int i = 0; i < 3; i++) begin
            w_t[i] = w_s4t[2*i] - w_s4t[2*i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t4[i] <= w_t[i][RW-1:0];
            end
            r_l4   <= r_l3;
            r_f4   <= r_f3;
            r_e4   <= r_e3;
            r_deg4 <= r_deg3;
        end
    end

    // Row 0 is left, row 1 true up, row 2 the negated forward vector.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_row[0][i] = r_l4[i];
            w_row[1][i] = r_t4[i];
            w_row[2][i] = -RW'(r_f4[i]);
            w_em[i]     = W'((r_e4[i] < 0) ? -r_e4[i] : r_e4[i]);
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                w_rm[k][i] = (RW-1)'((w_row[k][i] < 0) ? -w_row[k][i] : w_row[k][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_p5[k][i] <= w_rm[k][i] * w_em[i];
                    r_n5[k][i] <= (w_row[k][i] < 0) != (r_e4[i] < 0);
                end
            end
            r_row5 <= w_row;
            r_deg5 <= r_deg4;
        end
    end

    // Translation entry of each row is minus its dot product with the eye, saturated.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                w_hsh[k][i] = (P5W-F)'(r_p5[k][i] >> F);
                w_ht[k][i]  = r_n5[k][i] ? -SXW'($signed({1'b0, w_hsh[k][i]}))
                                         : SXW'($signed({1'b0, w_hsh[k][i]}));
            end
            w_dot[k] = w_ht[k][0] + w_ht[k][1] + w_ht[k][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hold_free) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_hold[k][i] <= sat_w(SXW'(r_row5[k][i]));
                end
                r_hold[k][3] <= sat_w(-w_dot[k]);
            end
            r_hdeg <= r_deg5;
        end
    end

    // The bottom row is the constant 0 0 0 1 and needs no storage.
    assign o_out_valid = r_hv;

    always_comb begin
        o_out_req.row_index  = r_row;
        o_out_req.last_row   = (r_row == LAST_ROW);
        o_out_req.degenerate = r_hdeg;
        if (r_row == LAST_ROW) begin
            o_out_req.col0 = '0;
            o_out_req.col1 = '0;
            o_out_req.col2 = '0;
            o_out_req.col3 = sat_w(ONE_X);
        end else begin
            o_out_req.col0 = r_hold[r_row][0];
            o_out_req.col1 = r_hold[r_row][1];
            o_out_req.col2 = r_hold[r_row][2];
            o_out_req.col3 = r_hold[r_row][3];
        end
    end

    `LAVM_ASSERT_IMP(a_norm_lockstep, 1'b1, w_f_v == w_u_v, "normalizer pipelines out of step")
    `LAVM_ASSERT_NXT(a_row_step, r_hv && i_out_ready && (r_row != LAST_ROW), r_hv && (r_row == $past(r_row) + 2'd1), "row counter did not step")
    `LAVM_ASSERT_NXT(a_stall_keeps, r_v5 && !w_en, r_v5 && $stable(r_p5[0][0]) && $stable(r_deg5), "stalled request changed")
    `LAVM_ASSERT_NXT(a_load_row0, w_hold_free && r_v5, r_hv && (r_row == 2'd0), "new matrix not started at row 0")

endmodule

// File: test/look_at_view_matrix_top_tb.sv
module look_at_view_matrix_top_tb;
    import lavm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = DEF_FRAC_BITS;

    // Magnitudes of sums of products reach about 2^100, so 128-bit signed math
    // is used everywhere in the predictor.
    typedef logic signed [127:0] t_wide;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_req o_out_req;

    // Rows still owed by the block, oldest first.
    t_out_req expected_rows[$];
    int       error_count;
    bit       sink_stall_on;

    look_at_view_matrix_top #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    // The clock runs with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Fixed-point product: the magnitude of the exact product is shifted right,
    // so the result is rounded toward zero.
    function automatic t_wide fx_mul(t_wide a, t_wide b);
        t_wide ma;
        t_wide mb;
        t_wide m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb) >>> FRAC;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic t_wide clamp_coord(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Scales a vector to unit length. The length is the floor of the square
    // root of the exact sum of squares; it returns 0 for a zero vector, whose
    // result is then all zero.
    function automatic bit unit_vector(input t_wide v[3], output t_wide o[3]);
        t_wide sum;
        t_wide len;
        t_wide c;
        t_wide m;
        sum = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        len = 0;
        for (int b = 52; b >= 0; b--) begin
            c = len | (t_wide'(1) <<< b);
            if (c * c <= sum) begin
                len = c;
            end
        end
        for (int i = 0; i < 3; i++) begin
            o[i] = 0;
        end
        if (len == 0) begin
            return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? -v[i] : v[i];
            m = (m <<< FRAC) / len;
            o[i] = (v[i] < 0) ? -m : m;
        end
        return 1'b1;
    endfunction

    function automatic void cross_product(input t_wide a[3], input t_wide b[3],
                                          output t_wide o[3]);
        o[0] = fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
        o[1] = fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
        o[2] = fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
    endfunction

    // Works out the four matrix rows of one request and queues them.
    task automatic predict_view_rows(input t_in_req r);
        t_wide    eye[3];
        t_wide    diff[3];
        t_wide    upv[3];
        t_wide    fwd[3];
        t_wide    upn[3];
        t_wide    rows[3][3];
        t_wide    dot;
        bit       ok_f;
        bit       ok_u;
        bit       degen;
        t_out_req row;
        eye[0] = t_wide'(r.eye_x);
        eye[1] = t_wide'(r.eye_y);
        eye[2] = t_wide'(r.eye_z);
        diff[0] = t_wide'(r.target_x) - eye[0];
        diff[1] = t_wide'(r.target_y) - eye[1];
        diff[2] = t_wide'(r.target_z) - eye[2];
        upv[0] = t_wide'(r.up_x);
        upv[1] = t_wide'(r.up_y);
        upv[2] = t_wide'(r.up_z);
        ok_f = unit_vector(diff, fwd);
        ok_u = unit_vector(upv, upn);
        cross_product(fwd, upn, rows[0]);
        cross_product(rows[0], fwd, rows[1]);
        for (int i = 0; i < 3; i++) begin
            rows[2][i] = -fwd[i];
        end
        degen = !ok_f || !ok_u || (rows[0][0] == 0 && rows[0][1] == 0 && rows[0][2] == 0);
        for (int k = 0; k < 3; k++) begin
            dot = fx_mul(rows[k][0], eye[0]) + fx_mul(rows[k][1], eye[1])
                + fx_mul(rows[k][2], eye[2]);
            row.col0 = COORD_WIDTH'(clamp_coord(rows[k][0]));
            row.col1 = COORD_WIDTH'(clamp_coord(rows[k][1]));
            row.col2 = COORD_WIDTH'(clamp_coord(rows[k][2]));
            row.col3 = COORD_WIDTH'(clamp_coord(-dot));
            row.row_index = 2'(k);
            row.last_row = 1'b0;
            row.degenerate = degen;
            expected_rows.push_back(row);
        end
        row.col0 = '0;
        row.col1 = '0;
        row.col2 = '0;
        row.col3 = COORD_WIDTH'(clamp_coord(t_wide'(1) <<< FRAC));
        row.row_index = LAST_ROW;
        row.last_row = 1'b1;
        row.degenerate = degen;
        expected_rows.push_back(row);
    endtask

    // Sends one request after a random gap. The gap is drawn per request so
    // that it lands on every phase of the four-row output sequence. Valid is
    // dropped only when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(input t_in_req r, input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_view_rows(r);
    endtask

    function automatic t_in_req make_request(logic signed [31:0] ex, ey, ez, tx, ty, tz,
                                             ux, uy, uz);
        t_in_req r;
        r.eye_x = ex;
        r.eye_y = ey;
        r.eye_z = ez;
        r.target_x = tx;
        r.target_y = ty;
        r.target_z = tz;
        r.up_x = ux;
        r.up_y = uy;
        r.up_z = uz;
        return r;
    endfunction

    // Coordinates of a random scale: small values make ordinary cameras, and
    // full-range words exercise overflow of the translation column.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            1: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            2: return $urandom;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // Directed requests: typical cameras, zero-length forward, zero up,
    // up parallel to forward and the extreme field values.
    task automatic test_directed_cameras();
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        send_request(make_request(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0), 2);
        send_request(make_request(ONE, 2 * ONE, 3 * ONE, -ONE, 0, 7, 0, 0, 3 * ONE), 2);
        send_request(make_request(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0), 2);
        send_request(make_request(0, 0, 0, ONE, 0, 0, 0, 0, 0), 2);
        send_request(make_request(0, 0, 0, 0, ONE, 0, 0, 4 * ONE, 0), 2);
        send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0), 2);
        send_request(make_request(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV), 2);
        send_request(make_request(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MINV), 2);
        send_request(make_request(MAXV, MINV, MAXV, MAXV, MAXV, MINV, 1, 0, -1), 2);
        send_request(make_request(-1, -1, -1, 1, 0, 0, 0, 1, 0), 2);
        send_request(make_request(MINV, 0, 0, 0, 0, 0, 0, 0, MINV), 2);
        send_request(make_request(MAXV, MAXV, MINV, 0, 0, 0, 0, ONE, ONE), 2);
        send_request(make_request(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                  32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                                  32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555), 2);
    endtask

    // Random cameras with random idle gaps at the input and random stalls at the sink.
    task automatic test_random_cameras(input int count);
        t_in_req r;
        for (int n = 0; n < count; n++) begin
            r = make_request(rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord());
            // Now and then the target repeats the eye or up is left zero.
            if ($urandom_range(0, 19) == 0) begin
                r.target_x = r.eye_x;
                r.target_y = r.eye_y;
                r.target_z = r.eye_z;
            end
            if ($urandom_range(0, 19) == 0) begin
                r.up_x = 0;
                r.up_y = 0;
                r.up_z = 0;
            end
            send_request(r, 6);
        end
    endtask

    // Back-to-back requests with the sink always ready, at full rate.
    task automatic test_back_to_back(input int count);
        sink_stall_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_request(make_request(rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord()), 0);
        end
        sink_stall_on = 1'b1;
    endtask

    // While sink stalls are on, the sink holds ready low for a random number of cycles between rows.
    always @(posedge i_clk) begin
        int stall_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            stall_left = sink_stall_on ? $urandom_range(0, 6) : 0;
            i_out_ready <= (stall_left == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compares every accepted row with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                $error("row with no request outstanding: %p", o_out_req);
                error_count++;
            end else begin
                want = expected_rows.pop_front();
                if (o_out_req.col0 !== want.col0) begin
                    $error("col0 expected %0d actual %0d", want.col0, o_out_req.col0);
                    error_count++;
                end
                if (o_out_req.col1 !== want.col1) begin
                    $error("col1 expected %0d actual %0d", want.col1, o_out_req.col1);
                    error_count++;
                end
                if (o_out_req.col2 !== want.col2) begin
                    $error("col2 expected %0d actual %0d", want.col2, o_out_req.col2);
                    error_count++;
                end
                if (o_out_req.col3 !== want.col3) begin
                    $error("col3 expected %0d actual %0d", want.col3, o_out_req.col3);
                    error_count++;
                end
                if (o_out_req.row_index !== want.row_index) begin
                    $error("row_index expected %0d actual %0d", want.row_index,
                           o_out_req.row_index);
                    error_count++;
                end
                if (o_out_req.last_row !== want.last_row) begin
                    $error("last_row expected %0d actual %0d", want.last_row,
                           o_out_req.last_row);
                    error_count++;
                end
                if (o_out_req.degenerate !== want.degenerate) begin
                    $error("degenerate expected %0d actual %0d", want.degenerate,
                           o_out_req.degenerate);
                    error_count++;
                end
            end
        end
    end

    // Run limit: the slowest correct run is well under 100 us.
    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        error_count = 0;
        sink_stall_on = 1'b1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cameras();
        test_random_cameras(160);
        test_back_to_back(40);
        i_in_valid <= 1'b0;

        // Drain, then give the pipeline its latency to show any stray row.
        while (expected_rows.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (COORD_WIDTH + FRAC + 20) @(posedge i_clk);

        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
